// ===== rtl/lsrp_pkg.sv =====
package lsrp_pkg;

  // Byte and character coding of the response stream.
  localparam logic [7:0] LF_BYTE     = 8'h0A;
  localparam logic [5:0] CHAR_OFFSET = 6'h30;

  // Field widths.
  localparam int SIX_W   = 6;
  localparam int VAL_W   = 18;
  localparam int IDX_W   = 11;
  localparam int LINE_W  = 8;
  localparam int HDR_W   = 3;
  localparam int CFG_W   = 11;
  localparam int CFG_A_W = 2;

  // Five characters of a group are held before the sixth completes it.
  localparam int ACC_W = 5 * SIX_W;
  localparam logic [2:0] GROUP_LAST = 3'd5;

  // Command queue between the front and the back.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_DATA_LINES   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_HEADER_LINES = 2'd2;

  // Reset values of the registers.
  localparam logic [IDX_W-1:0]  POINT_COUNT_RST  = 11'd1081;
  localparam logic [LINE_W-1:0] DATA_LINES_RST   = 8'd102;
  localparam logic [HDR_W-1:0]  HEADER_LINES_RST = 3'd3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_DATA    = 3'b010,
    PH_TRAILER = 3'b100
  } phase_t;

  // One command from the front: a stream character or a rearm marker.
  typedef struct packed {
    logic             rearm;
    logic [SIX_W-1:0] six;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [VAL_W-1:0] distance_mm;
    logic [VAL_W-1:0] reflectance_raw;
    logic [IDX_W-1:0] point_index;
    logic             last_point;
  } result_t;

endpackage

// ===== rtl/lsrp_front.sv =====
module lsrp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  input  logic [7:0]                 rx_byte,
  input  logic [lsrp_pkg::LINE_W-1:0] data_line_count,
  input  logic [lsrp_pkg::HDR_W-1:0]  header_line_count,
  output logic                       cmd_valid,
  output lsrp_pkg::cmd_t             cmd
);
  import lsrp_pkg::*;

  phase_t            phase, phase_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;
  logic [SIX_W-1:0]  held_six, held_six_next;
  logic              held_valid, held_valid_next;

  phase_t            eff_phase;
  logic [LINE_W-1:0] eff_line;
  logic [LINE_W-1:0] line_inc;
  logic              is_lf;

  // Classify the byte against the line structure of the response.
  always_comb begin
    is_lf = (rx_byte == LF_BYTE);
    eff_phase = phase;
    eff_line = line_counter;
    // A header already complete moves to the data phase before the byte is handled.
    if (phase == PH_HEADER && line_counter >= {{(LINE_W-HDR_W){1'b0}}, header_line_count}) begin
      eff_phase = PH_DATA;
      eff_line = '0;
    end
    line_inc = eff_line + 1'b1;

    phase_next = eff_phase;
    line_counter_next = eff_line;
    held_six_next = held_six;
    held_valid_next = held_valid;
    cmd_valid = 1'b0;
    cmd.rearm = 1'b0;
    cmd.six = held_six;

    case (eff_phase)
      PH_HEADER: begin
        if (is_lf) begin
          line_counter_next = line_inc;
          if (line_inc >= {{(LINE_W-HDR_W){1'b0}}, header_line_count}) begin
            phase_next = PH_DATA;
            line_counter_next = '0;
          end
        end
      end
      PH_DATA: begin
        if (is_lf) begin
          // The held character is the sum character of the line and is dropped.
          held_valid_next = 1'b0;
          held_six_next = '0;
          line_counter_next = line_inc;
          if (line_inc >= data_line_count) begin
            phase_next = PH_TRAILER;
            line_counter_next = '0;
          end
        end else begin
          cmd_valid = held_valid;
          held_six_next = rx_byte[SIX_W-1:0] - CHAR_OFFSET;
          held_valid_next = 1'b1;
        end
      end
      PH_TRAILER: begin
        if (is_lf) begin
          phase_next = PH_HEADER;
          line_counter_next = '0;
          held_six_next = '0;
          held_valid_next = 1'b0;
          cmd_valid = 1'b1;
          cmd.rearm = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        line_counter_next = '0;
      end
    endcase

    if (!byte_valid) begin
      phase_next = phase;
      line_counter_next = line_counter;
      held_six_next = held_six;
      held_valid_next = held_valid;
      cmd_valid = 1'b0;
    end
  end

  // Line tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      line_counter <= '0;
      held_six <= '0;
      held_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      line_counter <= line_counter_next;
      held_six <= held_six_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

// ===== rtl/lsrp_cmd_queue.sv =====
module lsrp_cmd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  lsrp_pkg::cmd_t      push_cmd,
  input  logic                pop_en,
  output lsrp_pkg::cmd_t      head,
  output lsrp_pkg::q_status_t status
);
  import lsrp_pkg::*;

  cmd_t                slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_push, do_pop;

  // Occupancy flags and the oldest entry.
  always_comb begin
    status.full = (count == CQ_CNT_W'(CQ_DEPTH));
    status.empty = (count == '0);
    do_push = push_en && !status.full;
    do_pop = pop_en && !status.empty;
    head = slots[rd_ptr];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lsrp_back.sv =====
module lsrp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lsrp_pkg::cmd_t             head,
  input  logic                       head_valid,
  output logic                       head_take,
  input  logic [lsrp_pkg::IDX_W-1:0] point_count,
  input  logic                       out_pop,
  output logic                       out_valid,
  output lsrp_pkg::result_t          result
);
  import lsrp_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [2:0]       group_pos;
  logic [IDX_W-1:0] point_counter;

  logic                   is_char, is_final, emits, out_free;
  logic [ACC_W+SIX_W-1:0] group;
  logic [IDX_W:0]         next_count;

  // Decide whether the head command can be carried out this cycle.
  always_comb begin
    is_char = head_valid && !head.rearm;
    is_final = (group_pos == GROUP_LAST);
    emits = is_char && is_final && (point_counter < point_count);
    out_free = !out_valid || out_pop;
    head_take = head_valid && (!emits || out_free);
    group = {acc, head.six};
    next_count = {1'b0, point_counter} + 1'b1;
  end

  // Group assembly and point counting.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      group_pos <= '0;
      point_counter <= '0;
    end else if (head_take) begin
      if (head.rearm) begin
        acc <= '0;
        group_pos <= '0;
        point_counter <= '0;
      end else if (is_final) begin
        acc <= '0;
        group_pos <= '0;
        if (emits) begin
          point_counter <= next_count[IDX_W-1:0];
        end
      end else begin
        acc <= group[ACC_W-1:0];
        group_pos <= group_pos + 1'b1;
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (head_take && emits) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take && emits) begin
      result.distance_mm <= group[2*VAL_W-1:VAL_W];
      result.reflectance_raw <= group[VAL_W-1:0];
      result.point_index <= point_counter;
      result.last_point <= (next_count == {1'b0, point_count});
    end
  end

endmodule

// ===== rtl/laser_scan_response_parser_core.sv =====
// Range response parser for a laser scanner, three-character encoding.
// Input channel: write one received byte on rx_byte with push; a beat is
// taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest point is on distance_mm,
// reflectance_raw, point_index and last_point; pop takes that beat.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge
// (0 point count, 1 data line count, 2 header line count); other indexes
// are ignored. Write only while no response is in flight.
// Throughput is one byte per cycle while full is low. The front tracks
// lines and passes each data character through a four-entry command queue
// to the back, which builds six-character groups and loads a one-beat
// result register. A point is loaded there when the back takes its sixth
// character, which the front passes on with the byte after it; the last
// character of a line waits until it is shown not to be the sum character.
// When the receiver stalls, the back holds its point and runs on until its
// next point is complete; that character waits at the head of the queue,
// the queue fills after three more characters and full rises, so no beat
// is lost. Synchronous reset restores the register defaults (1081, 102, 3),
// clears the queue and the result register and rearms at the header.
module laser_scan_response_parser_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic [lsrp_pkg::VAL_W-1:0]   distance_mm,
  output logic [lsrp_pkg::VAL_W-1:0]   reflectance_raw,
  output logic [lsrp_pkg::IDX_W-1:0]   point_index,
  output logic                         last_point,
  input  logic                         cfg_we,
  input  logic [lsrp_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [lsrp_pkg::CFG_W-1:0]   cfg_data
);
  import lsrp_pkg::*;

  logic [IDX_W-1:0]  point_count;
  logic [LINE_W-1:0] data_line_count;
  logic [HDR_W-1:0]  header_line_count;

  logic      byte_valid, cmd_valid, head_take, out_valid;
  cmd_t      cmd, head;
  q_status_t cq_status;
  result_t   result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
      data_line_count <= DATA_LINES_RST;
      header_line_count <= HEADER_LINES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT:  point_count <= cfg_data[IDX_W-1:0];
        REG_DATA_LINES:   data_line_count <= cfg_data[LINE_W-1:0];
        REG_HEADER_LINES: header_line_count <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel handshakes.
  assign full = cq_status.full;
  assign byte_valid = push && !full;
  assign empty = !out_valid;

  lsrp_front u_front (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .rx_byte           (rx_byte),
    .data_line_count   (data_line_count),
    .header_line_count (header_line_count),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd)
  );

  lsrp_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_en  (cmd_valid),
    .push_cmd (cmd),
    .pop_en   (head_take),
    .head     (head),
    .status   (cq_status)
  );

  lsrp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!cq_status.empty),
    .head_take   (head_take),
    .point_count (point_count),
    .out_pop     (pop && out_valid),
    .out_valid   (out_valid),
    .result      (result)
  );

  assign distance_mm = result.distance_mm;
  assign reflectance_raw = result.reflectance_raw;
  assign point_index = result.point_index;
  assign last_point = result.last_point;

`ifndef ASSERT_OFF
  // Reset leaves no point waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // A waiting point always lies inside the configured scan.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> point_index < point_count)
    else $error("point index beyond point count");

  // The last-point flag marks exactly the final index of the scan.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_point == ({1'b0, point_index} + 1'b1 == {1'b0, point_count})))
    else $error("last point flag inconsistent with index");

  // The command queue cannot report full and empty together.
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    cq_status.full |-> !cq_status.empty)
    else $error("command queue flags inconsistent");
`endif

endmodule

// ===== tb/sv/tb_laser_scan_response_parser_core.sv =====
`timescale 1ns / 100ps

module tb_laser_scan_response_parser_core;
  import lsrp_pkg::*;

  // Index that decodes to no register; writes to it must change nothing.
  localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS = 100;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES = 70;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] rx_byte = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic [VAL_W-1:0] distance_mm;
  logic [VAL_W-1:0] reflectance_raw;
  logic [IDX_W-1:0] point_index;
  logic last_point;
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  laser_scan_response_parser_core uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .distance_mm(distance_mm),
    .reflectance_raw(reflectance_raw),
    .point_index(point_index),
    .last_point(last_point),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the parser state and its registers.
  phase_t pr_phase;
  logic [LINE_W-1:0] pr_lines;
  logic [7:0] pr_held;
  logic pr_held_ok;
  logic [2:0] pr_grp_pos;
  logic [35:0] pr_grp_acc;
  logic [IDX_W-1:0] pr_pt_cnt;
  logic [IDX_W-1:0] cfg_points;
  logic [LINE_W-1:0] cfg_data_lines;
  logic [HDR_W-1:0] cfg_hdr_lines;

  result_t point_q[$];
  logic [7:0] byte_q[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  int in_wait = -1;
  int out_wait = -1;
  int mismatch_cnt = 0;

  task note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("%0t: %s", $time, msg);
  endtask

  task check_field(input string name, input logic [VAL_W-1:0] got,
                   input logic [VAL_W-1:0] want, input logic [IDX_W-1:0] idx);
    if (got !== want)
      note_mismatch($sformatf("point %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  task rearm_scan();
    pr_phase = PH_HEADER;
    pr_lines = '0;
    pr_held = 8'h00;
    pr_held_ok = 1'b0;
    pr_grp_pos = '0;
    pr_grp_acc = '0;
    pr_pt_cnt = '0;
  endtask

  // Adds one stream character to the group; a full group may yield a point.
  task take_char(input logic [7:0] c);
    logic [7:0] diff;
    result_t pt;
    diff = c - 8'h30;
    pr_grp_acc = {pr_grp_acc[29:0], diff[5:0]};
    if (pr_grp_pos == GROUP_LAST) begin
      pr_grp_pos = '0;
      if (pr_pt_cnt < cfg_points) begin
        pt.distance_mm = pr_grp_acc[35:18];
        pt.reflectance_raw = pr_grp_acc[17:0];
        pt.point_index = pr_pt_cnt;
        pt.last_point = (pr_pt_cnt + 1'b1 == cfg_points);
        point_q.push_back(pt);
        pr_pt_cnt = pr_pt_cnt + 1'b1;
      end
      pr_grp_acc = '0;
    end else begin
      pr_grp_pos = pr_grp_pos + 1'b1;
    end
  endtask

  // Line tracking for one received byte.
  task parse_byte(input logic [7:0] b);
    if (pr_phase == PH_HEADER && pr_lines >= cfg_hdr_lines) begin
      pr_phase = PH_DATA;
      pr_lines = '0;
    end
    case (pr_phase)
      PH_HEADER: begin
        if (b == LF_BYTE) begin
          pr_lines = pr_lines + 1'b1;
          if (pr_lines >= cfg_hdr_lines) begin
            pr_phase = PH_DATA;
            pr_lines = '0;
          end
        end
      end
      PH_DATA: begin
        if (b == LF_BYTE) begin
          // The held character was the sum character; drop it.
          pr_held_ok = 1'b0;
          pr_held = 8'h00;
          pr_lines = pr_lines + 1'b1;
          if (pr_lines >= cfg_data_lines) begin
            pr_phase = PH_TRAILER;
            pr_lines = '0;
          end
        end else begin
          if (pr_held_ok) take_char(pr_held);
          pr_held = b;
          pr_held_ok = 1'b1;
        end
      end
      default: begin
        if (b == LF_BYTE) rearm_scan();
      end
    endcase
  endtask

  // Sample both handshakes at the rising edge; predict and check.
  always @(posedge clk) begin : watch_beats
    result_t want;
    in_fire = !rst && push && !full;
    out_fire = !rst && pop && !empty;
    if (in_fire) parse_byte(rx_byte);
    if (out_fire) begin
      if (point_q.size() == 0) begin
        note_mismatch($sformatf("point %0d arrived with none pending", point_index));
      end else begin
        want = point_q.pop_front();
        check_field("distance_mm", distance_mm, want.distance_mm, want.point_index);
        check_field("reflectance_raw", reflectance_raw, want.reflectance_raw,
                    want.point_index);
        check_field("point_index", point_index, want.point_index, want.point_index);
        check_field("last_point", last_point, want.last_point, want.point_index);
      end
    end
  end

  // Byte sender: one beat at a time from byte_q, random wait first while idle_in.
  always @(negedge clk) begin : feed_bytes
    logic go;
    go = push && !in_fire;
    if (rst) begin
      go = 1'b0;
    end else if (!go) begin
      if (in_wait < 0 && byte_q.size() > 0) in_wait = idle_in ? $urandom_range(0, 15) : 0;
      if (in_wait == 0) begin
        rx_byte <= byte_q.pop_front();
        go = 1'b1;
        in_wait = -1;
      end else begin
        if (in_wait > 0) in_wait--;
        rx_byte <= 8'($urandom);
      end
    end
    push <= go;
  end

  // Point receiver: after each beat it waits a random time while idle_out is set.
  always @(negedge clk) begin : drain_points
    logic want_pop;
    want_pop = pop && !out_fire;
    if (rst) begin
      want_pop = 1'b0;
    end else if (!want_pop) begin
      if (out_wait < 0) out_wait = idle_out ? $urandom_range(0, 15) : 0;
      if (out_wait == 0) begin
        want_pop = 1'b1;
        out_wait = -1;
      end else begin
        out_wait--;
      end
    end
    pop <= want_pop;
  end

  function automatic logic [7:0] stream_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) != 0) c = 8'($urandom_range(0, 63)) + 8'h30;
    else c = 8'($urandom_range(0, 255));
    if (c == LF_BYTE) c = 8'h30;
    return c;
  endfunction

  task wait_sent();
    while (byte_q.size() != 0 || push) @(posedge clk);
  endtask

  // Waits until every byte is taken and every predicted point has come out.
  task settle();
    int guard;
    wait_sent();
    guard = 0;
    while (point_q.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends line feeds until the parser is back at the start of a response.
  task finish_scan();
    while (!(pr_phase == PH_HEADER && pr_lines == 0)) begin
      byte_q.push_back(LF_BYTE);
      wait_sent();
    end
    settle();
  endtask

  task write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POINT_COUNT: cfg_points = val[IDX_W-1:0];
      REG_DATA_LINES: cfg_data_lines = val[LINE_W-1:0];
      REG_HEADER_LINES: cfg_hdr_lines = val[HDR_W-1:0];
      default: ;
    endcase
  endtask

  // Upper bits above the line count registers' widths carry junk to be dropped.
  task set_config(input logic [IDX_W-1:0] pts, input logic [LINE_W-1:0] lines,
                  input logic [HDR_W-1:0] hdr);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    write_reg(REG_POINT_COUNT, pts);
    write_reg(REG_DATA_LINES, {junk[2:0], lines});
    write_reg(REG_HEADER_LINES, {junk[10:3], hdr});
    write_reg(REG_UNUSED, CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Builds one response for the current registers: header lines, data lines
  // carrying n_chars stream characters plus sum characters, and a trailer.
  // A broken response is cut short, corrupted, or replaced by noise.
  task queue_response(input int n_chars, input bit broken, inout int sent);
    logic [7:0] resp[$];
    int left;
    int lines_left;
    int take;
    int cut;
    resp = {};
    repeat (cfg_hdr_lines) begin
      repeat ($urandom_range(0, 6)) resp.push_back(stream_char());
      resp.push_back(LF_BYTE);
    end
    lines_left = (cfg_data_lines == 0) ? 1 : cfg_data_lines;
    left = n_chars;
    while (lines_left > 0) begin
      take = (lines_left == 1) ? left : $urandom_range(0, (2 * left) / lines_left);
      if (take > left) take = left;
      repeat (take) resp.push_back(stream_char());
      // An empty line now and then, or one holding only its sum character.
      if (take > 0 || $urandom_range(0, 1) == 0) resp.push_back(stream_char());
      resp.push_back(LF_BYTE);
      left -= take;
      lines_left--;
    end
    repeat ($urandom_range(0, 4)) resp.push_back(stream_char());
    resp.push_back(LF_BYTE);
    if (broken) begin
      case ($urandom_range(0, 2))
        0: begin
          cut = $urandom_range(0, resp.size() - 1);
          while (resp.size() > cut) resp.delete(resp.size() - 1);
        end
        1: begin
          repeat ($urandom_range(1, 3))
            resp[$urandom_range(0, resp.size() - 1)] =
              ($urandom_range(0, 1) == 0) ? LF_BYTE : 8'($urandom_range(0, 255));
        end
        default: begin
          resp = {};
          repeat ($urandom_range(8, 40))
            resp.push_back(($urandom_range(0, 3) == 0) ? LF_BYTE :
                           8'($urandom_range(0, 255)));
        end
      endcase
    end
    idle_in = $urandom_range(0, 3) != 0;
    idle_out = $urandom_range(0, 3) != 0;
    foreach (resp[i]) byte_q.push_back(resp[i]);
    sent += resp.size();
  endtask

  initial begin : stimulus
    string text;
    int sent;
    int n_chars;
    int ph;
    cfg_points = POINT_COUNT_RST;
    cfg_data_lines = DATA_LINES_RST;
    cfg_hdr_lines = HEADER_LINES_RST;
    rearm_scan();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A short response under the reset register values.
    sent = 0;
    queue_response(60, 1'b0, sent);
    settle();
    finish_scan();

    // Directed: full-scale distance then full-scale reflectance.
    set_config(11'd2, 8'd2, 3'd1);
    text = "H\nooo000Z\n000oooZ\nT\n";
    for (int i = 0; i < text.len(); i++) byte_q.push_back(text[i]);
    settle();
    finish_scan();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(11'd2047, 8'd20, 3'd3);
        1: set_config(11'd1, 8'd1, 3'd0);
        2: set_config(11'd0, 8'd0, 3'd7);
        3: set_config(IDX_W'($urandom_range(1, 20)), 8'd255, HDR_W'($urandom_range(0, 7)));
        4: set_config(11'd2047, 8'd3, 3'd7);
        5: set_config(IDX_W'($urandom_range(1, 24)), 8'd0, 3'd0);
        default: set_config(IDX_W'($urandom_range(1, 24)), LINE_W'($urandom_range(1, 8)),
                            HDR_W'($urandom_range(0, 7)));
      endcase
      sent = 0;
      if (ph == 0) begin
        // One scan at the largest point count; the data lines end first.
        queue_response(120, 1'b0, sent);
      end else begin
        while (sent < PHASE_BYTES) begin
          if (cfg_points > 24) begin
            n_chars = $urandom_range(0, 120);
          end else begin
            case ($urandom_range(0, 3))
              0, 1: n_chars = 6 * cfg_points;
              2: n_chars = 6 * cfg_points + $urandom_range(1, 20);
              default: n_chars = $urandom_range(0, 6 * cfg_points + 11);
            endcase
          end
          queue_response(n_chars, $urandom_range(0, 4) == 0, sent);
        end
      end
      settle();
      finish_scan();
    end

    settle();
    if (point_q.size() != 0)
      note_mismatch($sformatf("%0d predicted points never arrived", point_q.size()));
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
